// ===== rtl/mnee_pkg.sv =====
`timescale 1ns / 1ps

package mnee_pkg;

  // Field and datapath widths
  localparam int TICK_W     = 28;
  localparam int BYTE_W     = 8;
  localparam int CH_W       = 4;
  localparam int KIND_W     = 3;
  localparam int REC_W      = 48;
  localparam int USEC_W     = 24;
  localparam int PROD_W     = TICK_W + USEC_W;
  localparam int DEN_W      = 35;
  localparam int TPQ_W      = 15;
  localparam int UNIT_W     = 2;
  localparam int KEY_COUNT  = 128;
  localparam int KEY_W      = $clog2(KEY_COUNT);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 15;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_TIME_UNIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPQ       = 8'd1;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_TICKS = 2'd0,
    UNIT_BEATS = 2'd1,
    UNIT_SEC   = 2'd2,
    UNIT_MSEC  = 2'd3
  } unit_e;

  localparam logic [TPQ_W-1:0]  TPQ_RESET  = 15'd480;
  localparam logic [USEC_W-1:0] USEC_RESET = 24'd500000;

  // Status and meta codes
  localparam logic [BYTE_W-1:0] ST_META      = 8'hFF;
  localparam logic [3:0]        ST_SYS_NIB   = 4'hF;
  localparam logic [3:0]        DRUM_CH      = 4'h9;
  localparam logic [BYTE_W-1:0] CMD_NOTE_ON  = 8'h90;
  localparam logic [BYTE_W-1:0] CMD_NOTE_OFF = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_CTRL     = 8'hB0;
  localparam logic [BYTE_W-1:0] CMD_PROG     = 8'hC0;
  localparam logic [BYTE_W-1:0] META_TEMPO   = 8'h51;
  localparam logic [BYTE_W-1:0] META_METER   = 8'h58;
  localparam logic [BYTE_W-1:0] META_KEYSIG  = 8'h59;

  // Conversion constants
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0]  USEC_PER_MS  = 10'd1000;
  localparam logic [25:0] USEC_PER_MIN = 26'd60000000;
  localparam logic [REC_W-1:0] TIME_MAX = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_CTRL,
    OP_PROG,
    OP_SET_TEMPO,
    OP_SET_METER,
    OP_SET_KEY
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE   = 3'd0,
    KIND_CTRL   = 3'd1,
    KIND_PROG   = 3'd2,
    KIND_TEMPO  = 3'd3,
    KIND_METER  = 3'd4,
    KIND_KEYSIG = 3'd5
  } kind_e;

  typedef struct packed {
    op_e               op;
    logic [TICK_W-1:0] tick;
    logic [BYTE_W-1:0] track;
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] d1;
    logic [BYTE_W-1:0] d2;
    logic [BYTE_W-1:0] d3;
    logic [BYTE_W-1:0] d4;
    logic [BYTE_W-1:0] d5;
  } entry_t;

  typedef struct packed {
    unit_e            unit;
    logic [TPQ_W-1:0] tpq;
  } cfg_t;

endpackage

// ===== rtl/mnee_if.sv =====
`timescale 1ns / 1ps

interface mnee_evt_if;
  import mnee_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] abs_tick;
  logic [BYTE_W-1:0] track_num;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] data_one;
  logic [BYTE_W-1:0] data_two;
  logic [BYTE_W-1:0] data_three;
  logic [BYTE_W-1:0] data_four;
  logic [BYTE_W-1:0] data_five;
  modport source (output valid, abs_tick, track_num, status_byte, data_one, data_two,
                  data_three, data_four, data_five, input ready);
  modport sink (input valid, abs_tick, track_num, status_byte, data_one, data_two,
                data_three, data_four, data_five, output ready);
endinterface

interface mnee_rec_if;
  import mnee_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        record_kind;
  logic signed [REC_W-1:0]  start_time;
  logic signed [REC_W-1:0]  value_a;
  logic [BYTE_W-1:0]        value_b;
  logic signed [BYTE_W-1:0] velocity;
  logic [CH_W-1:0]          channel_num;
  logic [BYTE_W-1:0]        track_out;
  modport source (output valid, record_kind, start_time, value_a, value_b, velocity,
                  channel_num, track_out, input ready);
  modport sink (input valid, record_kind, start_time, value_a, value_b, velocity,
                channel_num, track_out, output ready);
endinterface

interface mnee_cfg_if;
  import mnee_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/midi_note_event_extractor.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// cfg_i     in   valid/ready    index (0 time_unit, 1 ticks_per_quarter), data
// evt_i     in   valid/ready    abs_tick, track_num, status_byte, data_one..data_five
// rec_o     out  valid/ready    record_kind, start_time, value_a, value_b, velocity,
//                               channel_num, track_out
//
// In the back end a record passes from pop to the result register through the bit-serial
// divider that rounds every time value; a tempo record runs it twice, for its time and its
// tempo in BPM. A note-on yields no record; it ends once its onset time is stored.
// Dropped items never reach the queue; tempo loads without a record end in the idle state.
// Reset clears the onset valid bits and loads the default tempo and register values; no clearing pass.
// A two-entry queue and a result register let the input keep flowing while rec_o stalls.
module midi_note_event_extractor #(
  parameter int FRAC_BITS = mnee_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mnee_cfg_if.sink   cfg_i,
  mnee_evt_if.sink   evt_i,
  mnee_rec_if.source rec_o
);
  import mnee_pkg::*;

  cfg_t   cfg_q;
  logic   push;
  entry_t push_entry;
  logic   q_ready;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  // Register writes; the user must send them only while the block is idle, as it does not enforce this
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit <= UNIT_BEATS;
      cfg_q.tpq  <= TPQ_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_TIME_UNIT) begin
        cfg_q.unit <= unit_e'(cfg_i.data[UNIT_W-1:0]);
      end else if (cfg_i.index == REG_TPQ) begin
        cfg_q.tpq <= cfg_i.data[TPQ_W-1:0];
      end
    end
  end

  mnee_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt       (evt_i),
    .push_o    (push),
    .entry_o   (push_entry),
    .q_ready_i (q_ready)
  );

  mnee_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  mnee_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .rec       (rec_o)
  );

endmodule

// ===== rtl/mnee_ram.sv =====
`timescale 1ns / 1ps

module mnee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mnee_div.sv =====
`timescale 1ns / 1ps

module mnee_div #(
  parameter int NUM_W = 69
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [mnee_pkg::DEN_W-1:0] den_i,
  output logic                       done_o,
  output logic [mnee_pkg::REC_W-1:0] quo_o
);
  import mnee_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam int QUO_W = REC_W - 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic             ovf_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: bring down the next numerator bit
  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], ge};
        ovf_q <= ovf_q | quo_q[QUO_W-1];
        num_q <= num_q << 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Saturate quotients that do not fit the signed result range
  assign done_o = done_q;
  assign quo_o  = ovf_q ? TIME_MAX : {1'b0, quo_q};

endmodule

// ===== rtl/mnee_front.sv =====
`timescale 1ns / 1ps

module mnee_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  mnee_evt_if.sink            evt,
  output logic                push_o,
  output mnee_pkg::entry_t    entry_o,
  input  logic                q_ready_i
);
  import mnee_pkg::*;

  logic   keep;
  op_e    op;
  logic [BYTE_W-1:0] cmd;
  logic   accept;
  logic   f_valid_q;
  entry_t f_entry_q;

  // Classify the incoming event; drums and unknown codes are dropped
  always_comb begin
    keep = 1'b1;
    op   = OP_CTRL;
    cmd  = (evt.status_byte[7:4] == ST_SYS_NIB) ? evt.status_byte
                                                : {evt.status_byte[7:4], 4'h0};
    if (evt.status_byte == ST_META && evt.data_one == META_TEMPO) begin
      op = OP_SET_TEMPO;
    end else if (evt.status_byte[3:0] == DRUM_CH) begin
      keep = 1'b0;
    end else begin
      unique case (cmd)
        CMD_NOTE_ON: begin
          op = (evt.data_two != '0) ? OP_NOTE_ON : OP_NOTE_OFF;
        end
        CMD_NOTE_OFF: op = OP_NOTE_OFF;
        CMD_CTRL:     op = OP_CTRL;
        CMD_PROG:     op = OP_PROG;
        ST_META: begin
          if (evt.data_one == META_METER) begin
            op = OP_SET_METER;
          end else if (evt.data_one == META_KEYSIG) begin
            op = OP_SET_KEY;
          end else begin
            keep = 1'b0;
          end
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign evt.ready = !f_valid_q || q_ready_i;
  assign accept    = evt.valid && evt.ready;

  // Hold one classified item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (accept) begin
      f_valid_q <= keep;
    end else if (q_ready_i) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_entry_q.op    <= op;
      f_entry_q.tick  <= evt.abs_tick;
      f_entry_q.track <= evt.track_num;
      f_entry_q.ch    <= evt.status_byte[3:0];
      f_entry_q.d1    <= evt.data_one;
      f_entry_q.d2    <= evt.data_two;
      f_entry_q.d3    <= evt.data_three;
      f_entry_q.d4    <= evt.data_four;
      f_entry_q.d5    <= evt.data_five;
    end
  end

  assign push_o  = f_valid_q;
  assign entry_o = f_entry_q;

endmodule

// ===== rtl/mnee_fifo.sv =====
`timescale 1ns / 1ps

module mnee_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mnee_pkg::entry_t entry_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mnee_pkg::entry_t entry_o
);
  import mnee_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign ready_o = cnt_q != (PTR_W+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_q];

  // Advance pointers with wrap at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/mnee_back.sv =====
`timescale 1ns / 1ps

module mnee_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mnee_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  mnee_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  mnee_rec_if.source       rec
);
  import mnee_pkg::*;

  localparam int NUM_W = PROD_W + FRAC_BITS + 1;
  localparam logic [REC_W-1:0] ONSET_NONE = {REC_W{1'b1}} << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NUM,
    S_TIME,
    S_BPM,
    S_RATE,
    S_OUT
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [REC_W-1:0]  start;
    logic [REC_W-1:0]  va;
    logic [BYTE_W-1:0] vb;
    logic [BYTE_W-1:0] vel;
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] track;
  } rec_t;

  state_e               state_q;
  entry_t               cur_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DEN_W-1:0]     den_q;
  logic [REC_W-1:0]     time_q;
  logic [REC_W-1:0]     bpm_q;
  logic [USEC_W-1:0]    usec_q;
  logic                 seen_q;
  logic [KEY_COUNT-1:0] valid_q;
  logic                 out_valid_q;
  rec_t                 out_q;

  logic [TPQ_W-1:0]  tpq_eff;
  logic [DEN_W-1:0]  den_d;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] src;
  logic [USEC_W-1:0] q_new_u;
  logic [USEC_W-1:0] new_u;
  logic [KEY_W-1:0]  key;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [REC_W-1:0]  div_quo;
  logic              ram_we;
  logic              ram_re;
  logic [REC_W+BYTE_W-1:0] ram_rdata;
  logic [REC_W-1:0]  onset;
  logic [BYTE_W-1:0] onset_vel;
  logic [REC_W:0]    dur;
  logic              out_free;
  rec_t              rec_d;

  assign q_new_u = {q_entry_i.d3, q_entry_i.d4, q_entry_i.d5};
  assign new_u   = {cur_q.d3, cur_q.d4, cur_q.d5};
  assign key     = cur_q.d1[KEY_W-1:0];

  // Denominator of the time conversion for the selected unit
  always_comb begin
    tpq_eff = (cfg_i.tpq == '0) ? TPQ_W'(1) : cfg_i.tpq;
    case (cfg_i.unit)
      UNIT_TICKS: den_d = DEN_W'(1);
      UNIT_BEATS: den_d = DEN_W'(tpq_eff);
      UNIT_SEC:   den_d = DEN_W'(tpq_eff) * DEN_W'(USEC_PER_SEC);
      default:    den_d = DEN_W'(tpq_eff) * DEN_W'(USEC_PER_MS);
    endcase
    prod_d = PROD_W'(cur_q.tick) * PROD_W'(usec_q);
    src    = (cfg_i.unit == UNIT_TICKS || cfg_i.unit == UNIT_BEATS) ? PROD_W'(cur_q.tick)
                                                                     : prod_q;
  end

  // Feed the divider: rounded time, then rounded tempo in BPM
  always_comb begin
    div_start = (state_q == S_NUM) || (state_q == S_BPM);
    if (state_q == S_BPM) begin
      div_num = (NUM_W'(USEC_PER_MIN) << FRAC_BITS) + NUM_W'(new_u >> 1);
      div_den = DEN_W'(new_u);
    end else begin
      div_num = (NUM_W'(src) << FRAC_BITS) + NUM_W'(den_q >> 1);
      div_den = den_q;
    end
  end

  mnee_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign ram_re = state_q == S_MUL;
  assign ram_we = (state_q == S_TIME) && div_done && (cur_q.op == OP_NOTE_ON);

  mnee_ram #(
    .WIDTH (REC_W + BYTE_W),
    .DEPTH (KEY_COUNT)
  ) u_onset_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (key),
    .wdata_i ({div_quo, cur_q.d2}),
    .re_i    (ram_re),
    .raddr_i (key),
    .rdata_o (ram_rdata)
  );

  // Build the record from the current item
  always_comb begin
    onset     = valid_q[key] ? ram_rdata[REC_W+BYTE_W-1:BYTE_W] : ONSET_NONE;
    onset_vel = valid_q[key] ? ram_rdata[BYTE_W-1:0] : {BYTE_W{1'b1}};
    dur       = {time_q[REC_W-1], time_q} - {onset[REC_W-1], onset};
    rec_d.kind  = KIND_NOTE;
    rec_d.start = time_q;
    rec_d.va    = '0;
    rec_d.vb    = '0;
    rec_d.vel   = '0;
    rec_d.ch    = cur_q.ch;
    rec_d.track = cur_q.track;
    case (cur_q.op)
      OP_NOTE_OFF: begin
        rec_d.start = onset;
        rec_d.va    = (!dur[REC_W] && dur[REC_W-1]) ? TIME_MAX : dur[REC_W-1:0];
        rec_d.vb    = BYTE_W'(key);
        rec_d.vel   = onset_vel;
      end
      OP_CTRL: begin
        rec_d.kind = KIND_CTRL;
        rec_d.va   = REC_W'(cur_q.d1);
        rec_d.vb   = cur_q.d2;
      end
      OP_PROG: begin
        rec_d.kind = KIND_PROG;
        rec_d.va   = REC_W'(cur_q.d1);
      end
      OP_SET_TEMPO: begin
        rec_d.kind = KIND_TEMPO;
        rec_d.va   = bpm_q;
        rec_d.ch   = '0;
      end
      OP_SET_METER: begin
        rec_d.kind = KIND_METER;
        rec_d.va   = REC_W'(cur_q.d3);
        rec_d.vb   = (cur_q.d4 < BYTE_W'(8)) ? (BYTE_W'(1) << cur_q.d4[2:0]) : '0;
        rec_d.ch   = '0;
      end
      OP_SET_KEY: begin
        rec_d.kind = KIND_KEYSIG;
        rec_d.va   = {{(REC_W-BYTE_W){cur_q.d3[BYTE_W-1]}}, cur_q.d3};
        rec_d.vb   = cur_q.d4;
        rec_d.ch   = '0;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || rec.ready;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  // Sequencer: take an item, convert time, update state, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      usec_q      <= USEC_RESET;
      seen_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the held record once taken, unless a new one replaces it
      if (rec.ready && !(state_q == S_OUT && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q <= q_entry_i;
            if (q_entry_i.op == OP_SET_TEMPO && !(seen_q && q_new_u != usec_q)) begin
              usec_q <= q_new_u;
              seen_q <= 1'b1;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= prod_d;
          den_q   <= den_d;
          state_q <= S_NUM;
        end
        S_NUM: begin
          state_q <= S_TIME;
        end
        S_TIME: begin
          if (div_done) begin
            time_q <= div_quo;
            if (cur_q.op == OP_NOTE_ON) begin
              valid_q[key] <= 1'b1;
              state_q      <= S_IDLE;
            end else if (cur_q.op == OP_SET_TEMPO && new_u != '0) begin
              state_q <= S_BPM;
            end else begin
              bpm_q   <= TIME_MAX;
              state_q <= S_OUT;
            end
          end
        end
        S_BPM: begin
          state_q <= S_RATE;
        end
        S_RATE: begin
          if (div_done) begin
            bpm_q   <= div_quo;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q       <= rec_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (cur_q.op == OP_SET_TEMPO) begin
              usec_q <= new_u;
              seen_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rec.valid       = out_valid_q;
  assign rec.record_kind = out_q.kind;
  assign rec.start_time  = out_q.start;
  assign rec.value_a     = out_q.va;
  assign rec.value_b     = out_q.vb;
  assign rec.velocity    = out_q.vel;
  assign rec.channel_num = out_q.ch;
  assign rec.track_out   = out_q.track;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mnee_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint unsigned TMAX = 64'h7FFF_FFFF_FFFF;
  localparam longint signed DMIN = -(64'sd1 <<< 47);
  localparam int TAIL_CYCLES = 400;

  typedef struct {
    logic [TICK_W-1:0] tick;
    logic [7:0] trk, st, d1, d2, d3, d4, d5;
  } midi_evt_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [REC_W-1:0] start, va;
    logic [7:0] vb, vel;
    logic [CH_W-1:0] ch;
    logic [7:0] trk;
  } midi_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mnee_cfg_if cfg_bus ();
  mnee_evt_if evt_bus ();
  mnee_rec_if rec_bus ();

  midi_note_event_extractor i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus.sink),
    .evt_i (evt_bus.sink),
    .rec_o (rec_bus.source)
  );

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block state
  longint signed   key_onset [KEY_COUNT];
  logic [7:0]      key_vel [KEY_COUNT];
  logic [USEC_W-1:0] tempo_usec;
  bit              tempo_loaded;
  logic [1:0]      cur_unit;
  logic [TPQ_W-1:0] cur_tpq;

  midi_evt_t event_q[$];
  midi_rec_t record_q[$];
  bit failed = 1'b0;
  bit calm = 1'b0;
  bit evt_took, rec_took;
  int send_gap = 0;
  int recv_gap = 0;

  // Generator state
  logic [TICK_W-1:0] gen_tick = '0;
  logic [23:0] gen_tempo = 24'd500000;

  // round(n * 2^FRAC / den), saturated
  function automatic longint unsigned round_div(longint unsigned n, longint unsigned den);
    longint unsigned q, r, v;
    q = n / den;
    r = n % den;
    if (q > (TMAX >> FRAC)) return TMAX;
    v = (q << FRAC) + ((r << FRAC) + den / 2) / den;
    return (v > TMAX) ? TMAX : v;
  endfunction

  function automatic longint unsigned tick_to_unit(longint unsigned t);
    longint unsigned tpq, tu;
    tpq = (cur_tpq == 0) ? 64'd1 : 64'(cur_tpq);
    tu = t * 64'(tempo_usec);
    case (cur_unit)
      UNIT_TICKS: return round_div(t, 1);
      UNIT_BEATS: return round_div(t, tpq);
      UNIT_SEC:   return round_div(tu, 64'd1000000 * tpq);
      default:    return round_div(tu, 64'd1000 * tpq);
    endcase
  endfunction

  // Update the shadow state for one item; return 1 if it yields a record
  function automatic bit predict_record(midi_evt_t e, output midi_rec_t r);
    logic [23:0] nu;
    logic [7:0] cmd;
    logic [6:0] key;
    longint signed dur;
    bit emit;
    emit = 1'b0;
    r = '{default: '0};
    r.trk = e.trk;
    if (e.st == ST_META && e.d1 == META_TEMPO) begin
      nu = {e.d3, e.d4, e.d5};
      if (tempo_loaded && nu != tempo_usec) begin
        emit = 1'b1;
        r.kind = KIND_TEMPO;
        r.start = REC_W'(tick_to_unit(64'(e.tick)));
        r.va = (nu == 0) ? REC_W'(TMAX) : REC_W'(round_div(64'd60000000, 64'(nu)));
      end
      tempo_usec = nu;
      tempo_loaded = 1'b1;
      return emit;
    end
    if (e.st[3:0] == DRUM_CH) return 1'b0;
    cmd = (e.st[7:4] == ST_SYS_NIB) ? e.st : {e.st[7:4], 4'h0};
    key = e.d1[6:0];
    r.ch = e.st[3:0];
    if (cmd == CMD_NOTE_ON && e.d2 != 0) begin
      key_onset[key] = longint'(tick_to_unit(64'(e.tick)));
      key_vel[key] = e.d2;
      return 1'b0;
    end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
      dur = longint'(tick_to_unit(64'(e.tick))) - key_onset[key];
      if (dur > longint'(TMAX)) dur = longint'(TMAX);
      if (dur < DMIN) dur = DMIN;
      r.kind = KIND_NOTE;
      r.start = REC_W'(key_onset[key]);
      r.va = REC_W'(dur);
      r.vb = {1'b0, key};
      r.vel = key_vel[key];
    end else if (cmd == CMD_CTRL) begin
      r.kind = KIND_CTRL;
      r.start = REC_W'(tick_to_unit(64'(e.tick)));
      r.va = REC_W'(e.d1);
      r.vb = e.d2;
    end else if (cmd == CMD_PROG) begin
      r.kind = KIND_PROG;
      r.start = REC_W'(tick_to_unit(64'(e.tick)));
      r.va = REC_W'(e.d1);
    end else if (cmd == ST_META && e.d1 == META_METER) begin
      r.kind = KIND_METER;
      r.start = REC_W'(tick_to_unit(64'(e.tick)));
      r.va = REC_W'(e.d3);
      r.vb = (e.d4 < 8) ? (8'd1 << e.d4) : 8'd0;
      r.ch = '0;
    end else if (cmd == ST_META && e.d1 == META_KEYSIG) begin
      r.kind = KIND_KEYSIG;
      r.start = REC_W'(tick_to_unit(64'(e.tick)));
      r.va = {{40{e.d3[7]}}, e.d3};
      r.vb = e.d4;
      r.ch = '0;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic midi_evt_t mk_evt(logic [TICK_W-1:0] t, logic [7:0] trk, logic [7:0] st,
                                       logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                       logic [7:0] d, logic [7:0] f);
    midi_evt_t e;
    e.tick = t; e.trk = trk; e.st = st; e.d1 = a; e.d2 = b; e.d3 = c; e.d4 = d; e.d5 = f;
    return e;
  endfunction

  // Build one random item, mostly well-formed note traffic
  function automatic midi_evt_t rand_evt();
    midi_evt_t e;
    int sel;
    logic [3:0] ch;
    sel = $urandom_range(0, 99);
    ch = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 19) == 0) gen_tick = TICK_W'($urandom);
    else gen_tick = gen_tick + TICK_W'($urandom_range(0, 2000));
    e = mk_evt(gen_tick, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
    if (sel < 55) begin
      e.d1 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(56, 71));
      if (sel < 30) begin
        e.st = CMD_NOTE_ON | ch;
        e.d2 = 8'($urandom_range(1, 127));
      end else if (sel < 45) begin
        e.st = CMD_NOTE_OFF | ch;
      end else begin
        e.st = CMD_NOTE_ON | ch;
        e.d2 = 8'd0;
      end
    end else if (sel < 63) e.st = CMD_CTRL | ch;
    else if (sel < 70) e.st = CMD_PROG | ch;
    else if (sel < 90) begin
      e.st = ST_META;
      if (sel < 78) begin
        e.d1 = META_TEMPO;
        case ($urandom_range(0, 5))
          0: gen_tempo = gen_tempo;
          1: gen_tempo = 24'd0;
          2: gen_tempo = 24'($urandom);
          default: gen_tempo = 24'($urandom_range(200000, 1500000));
        endcase
        {e.d3, e.d4, e.d5} = gen_tempo;
      end else if (sel < 84) begin
        e.d1 = META_METER;
        e.d4 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      end else begin
        e.d1 = META_KEYSIG;
      end
    end else if (sel < 95) begin
      e.st = {e.st[7:4], DRUM_CH};
    end
    return e;
  endfunction

  // Sample both channels; predict on input, check on output
  always @(posedge clk_i) begin
    midi_evt_t e;
    midi_rec_t exp_r, got;
    evt_took = evt_bus.valid && evt_bus.ready;
    rec_took = rec_bus.valid && rec_bus.ready;
    if (cfg_bus.valid && cfg_bus.ready) begin
      if (cfg_bus.index == REG_TIME_UNIT) cur_unit = cfg_bus.data[1:0];
      else if (cfg_bus.index == REG_TPQ) cur_tpq = cfg_bus.data[TPQ_W-1:0];
    end
    if (evt_took) begin
      e = mk_evt(evt_bus.abs_tick, evt_bus.track_num, evt_bus.status_byte, evt_bus.data_one,
                 evt_bus.data_two, evt_bus.data_three, evt_bus.data_four, evt_bus.data_five);
      if (predict_record(e, exp_r)) record_q = {record_q, exp_r};
    end
    if (rec_took) begin
      got = '{rec_bus.record_kind, rec_bus.start_time, rec_bus.value_a, rec_bus.value_b,
              rec_bus.velocity, rec_bus.channel_num, rec_bus.track_out};
      if (record_q.size() == 0) begin
        $error("record with no expectation: kind %0d", got.kind);
        failed = 1'b1;
      end else begin
        exp_r = record_q.pop_front();
        if (got.kind !== exp_r.kind) begin
          $error("record_kind: expected %0d, got %0d", exp_r.kind, got.kind); failed = 1'b1;
        end
        if (got.start !== exp_r.start) begin
          $error("start_time: expected %0d, got %0d", $signed(exp_r.start), $signed(got.start));
          failed = 1'b1;
        end
        if (got.va !== exp_r.va) begin
          $error("value_a: expected %0d, got %0d", $signed(exp_r.va), $signed(got.va));
          failed = 1'b1;
        end
        if (got.vb !== exp_r.vb) begin
          $error("value_b: expected %0d, got %0d", exp_r.vb, got.vb); failed = 1'b1;
        end
        if (got.vel !== exp_r.vel) begin
          $error("velocity: expected %0d, got %0d", $signed(exp_r.vel), $signed(got.vel));
          failed = 1'b1;
        end
        if (got.ch !== exp_r.ch) begin
          $error("channel_num: expected %0d, got %0d", exp_r.ch, got.ch); failed = 1'b1;
        end
        if (got.trk !== exp_r.trk) begin
          $error("track_out: expected %0d, got %0d", exp_r.trk, got.trk); failed = 1'b1;
        end
      end
    end
  end

  // Feed pending items, with random gap bursts
  always @(negedge clk_i) begin
    midi_evt_t e;
    if (rst_ni && (!evt_bus.valid || evt_took)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        evt_bus.valid <= 1'b0;
      end else if (event_q.size() == 0) begin
        evt_bus.valid <= 1'b0;
      end else begin
        e = event_q.pop_front();
        evt_bus.abs_tick <= e.tick;
        evt_bus.track_num <= e.trk;
        evt_bus.status_byte <= e.st;
        evt_bus.data_one <= e.d1;
        evt_bus.data_two <= e.d2;
        evt_bus.data_three <= e.d3;
        evt_bus.data_four <= e.d4;
        evt_bus.data_five <= e.d5;
        evt_bus.valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
      end
    end
  end

  // Stall the record side in random bursts
  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      rec_bus.ready <= 1'b0;
    end else begin
      rec_bus.ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 9);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Queue one pending item
  task automatic add_evt(midi_evt_t e);
    event_q = {event_q, e};
  endtask

  // Hold off until every item is through and every record has come
  task automatic drain();
    while (event_q.size() != 0 || evt_bus.valid || record_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(unit_e unit, logic [TPQ_W-1:0] tpq, int count);
    write_reg(REG_TIME_UNIT, CFG_DATA_W'(unit));
    write_reg(REG_TPQ, tpq);
    repeat (count) add_evt(rand_evt());
    drain();
  endtask

  initial begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_onset[k] = -(64'sd1 <<< FRAC);
      key_vel[k] = 8'hFF;
    end
    tempo_usec = USEC_RESET;
    tempo_loaded = 1'b0;
    cur_unit = UNIT_BEATS;
    cur_tpq = TPQ_RESET;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    evt_bus.valid = 1'b0;
    {evt_bus.abs_tick, evt_bus.track_num, evt_bus.status_byte, evt_bus.data_one} = '0;
    {evt_bus.data_two, evt_bus.data_three, evt_bus.data_four, evt_bus.data_five} = '0;
    rec_bus.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every record kind, the corner cases
    add_evt(mk_evt(28'd0, 8'd0, CMD_NOTE_ON, 8'd0, 8'd127, 8'h00, 8'h00, 8'h00));
    add_evt(mk_evt(28'd480, 8'd255, CMD_NOTE_OFF, 8'd0, 8'd64, 8'hFF, 8'hFF, 8'hFF));
    add_evt(mk_evt(28'd500, 8'd3, CMD_NOTE_ON | 8'h0F, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'd600, 8'd1, CMD_NOTE_ON | 8'h01, 8'hBC, 8'd1, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'd700, 8'd1, CMD_NOTE_OFF | 8'h01, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'd800, 8'd2, CMD_CTRL | 8'h03, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'd900, 8'd2, CMD_PROG, 8'hFF, 8'h00, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'd950, 8'd0, ST_META, META_TEMPO, 8'd3, 8'h07, 8'hA1, 8'h20));
    add_evt(mk_evt(28'd960, 8'd0, ST_META, META_TEMPO, 8'd3, 8'h07, 8'hA1, 8'h20));
    add_evt(mk_evt(28'd970, 8'd0, ST_META, META_TEMPO, 8'd3, 8'h00, 8'h00, 8'h00));
    add_evt(mk_evt(28'd980, 8'd0, ST_META, META_TEMPO, 8'd3, 8'hFF, 8'hFF, 8'hFF));
    add_evt(mk_evt(28'd990, 8'd0, ST_META, META_TEMPO, 8'd3, 8'h00, 8'h00, 8'h01));
    add_evt(mk_evt(28'd1000, 8'd0, ST_META, META_TEMPO, 8'd3, 8'h07, 8'hA1, 8'h20));
    add_evt(mk_evt(28'd1100, 8'd4, ST_META, META_METER, 8'd4, 8'd0, 8'd0, 8'd24));
    add_evt(mk_evt(28'd1200, 8'd4, ST_META, META_METER, 8'd4, 8'hFF, 8'd7, 8'd8));
    add_evt(mk_evt(28'd1300, 8'd4, ST_META, META_METER, 8'd4, 8'd6, 8'd8, 8'd8));
    add_evt(mk_evt(28'd1400, 8'd5, ST_META, META_KEYSIG, 8'd2, 8'h80, 8'd1, 8'd0));
    add_evt(mk_evt(28'd1500, 8'd5, ST_META, META_KEYSIG, 8'd2, 8'h7F, 8'hFF, 8'd0));
    add_evt(mk_evt(28'd1600, 8'd6, CMD_NOTE_ON | DRUM_CH, 8'd36, 8'd100, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'd1700, 8'd6, 8'hF0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5));
    add_evt(mk_evt(28'd1800, 8'd6, ST_META, 8'h01, 8'd0, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'h3FF_FFFF, 8'd7, CMD_NOTE_ON, 8'd5, 8'd90, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'hFFF_FFFF, 8'd7, CMD_NOTE_OFF, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0));
    add_evt(mk_evt(28'hFFF_FFFF, 8'd7, CMD_CTRL, 8'd7, 8'd1, 8'd0, 8'd0, 8'd0));
    drain();

    // Random phases across the register settings
    run_phase(UNIT_TICKS, 15'd1, 130);
    run_phase(UNIT_SEC, 15'd96, 130);
    run_phase(UNIT_MSEC, 15'd32767, 130);
    run_phase(UNIT_BEATS, 15'd0, 130);
    run_phase(UNIT_SEC, 15'd1, 130);
    run_phase(UNIT_BEATS, 15'd32767, 130);
    calm = 1'b1;
    run_phase(UNIT_MSEC, 15'd480, 100);

    if (!failed && record_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
